>>> src/fmos_pkg.sv
package fmos_pkg;

    localparam int VAL_W     = 32;
    localparam int POS_J_W   = 8;
    localparam int DOM_W     = 9;
    localparam int STR_W     = 11;
    localparam int SEL_W     = 8;
    localparam int CFG_W     = 11;
    localparam int REG_IDX_W = 2;

    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [REG_IDX_W-1:0]    reg_idx_t;

    localparam value_t NEG_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    localparam reg_idx_t REG_MODE_SELECT  = 2'd0;
    localparam reg_idx_t REG_DOM_SIZE     = 2'd1;
    localparam reg_idx_t REG_STRIDE       = 2'd2;
    localparam reg_idx_t REG_SELECT_VALUE = 2'd3;

endpackage

>>> src/factor_max_out_or_select.sv
// Removes one variable from a log10 factor table streamed in index order, one
// entry per transaction. In max mode each result is the maximum over the
// variable's values, in select mode the entry at the configured value; a
// result leaves on the entry that carries the variable's last value, and the
// highest result so far travels with it. The block takes one entry every
// cycle unless a waiting result stalls it. An entry reads its partial
// maximum from a MAX_STRIDE-deep buffer as it is accepted. It is compared in
// the next cycle, and as it leaves the s1 registers it is written back to the
// buffer (with bypass when the stride is one) and, if it ends a result, loaded
// into the result register. The input stalls only while a result waits and the
// entry behind it also produces a result. The user must write configuration
// only while no table is in progress; the block does not enforce it.
module factor_max_out_or_select #(
    parameter int MAX_STRIDE = 1024,
    parameter int MAX_DOM    = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  fmos_pkg::reg_idx_t                  cfg_addr,
    input  logic [fmos_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  fmos_pkg::value_t                    s_entry_value,
    input  logic                                s_last_entry,
    output logic                                m_valid,
    input  logic                                m_ready,
    output fmos_pkg::value_t                    m_result_value,
    output logic                                m_result_last,
    output fmos_pkg::value_t                    m_highest_value
);

    localparam int KW      = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
    localparam int DW      = fmos_pkg::DOM_W;
    localparam int SW      = fmos_pkg::STR_W;
    localparam int JW      = fmos_pkg::POS_J_W;
    localparam int STR_LIM = (MAX_STRIDE < 2047) ? MAX_STRIDE : 2047;
    localparam int DOM_LIM = (MAX_DOM < 511) ? MAX_DOM : 511;
    localparam int CW      = ((KW > SW) ? KW : SW) + 1;

    logic                          mode_reg;
    logic [DW-1:0]                 dom_reg;
    logic [SW-1:0]                 stride_reg;
    logic [fmos_pkg::SEL_W-1:0]    sel_reg;

    logic [DW-1:0]                 dom_eff;
    logic [SW-1:0]                 str_eff;

    logic [KW-1:0]                 k_reg;
    logic [JW-1:0]                 j_reg;
    logic [CW-1:0]                 k_inc;
    logic                          k_wrap;
    logic [DW-1:0]                 j_inc;
    logic                          j_end;
    logic                          s_accept;

    logic                          s1_valid_reg;
    fmos_pkg::value_t              s1_entry_reg;
    logic                          s1_last_reg;
    logic                          s1_emit_reg;
    logic                          s1_first_reg;
    logic                          s1_pick_reg;
    logic [KW-1:0]                 s1_k_reg;
    logic                          s1_adv;

    fmos_pkg::value_t              prev;
    fmos_pkg::value_t              cand;
    fmos_pkg::value_t              acc;
    fmos_pkg::value_t              hs_cand;
    fmos_pkg::value_t              hs_reg;

    logic                          m_valid_reg;
    logic                          m_valid_next;
    fmos_pkg::value_t              m_value_reg;
    logic                          m_last_reg;
    fmos_pkg::value_t              m_highest_reg;
    logic                          m_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            dom_reg    <= DW'(2);
            stride_reg <= SW'(1);
            sel_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                fmos_pkg::REG_MODE_SELECT:  mode_reg   <= cfg_wdata[0];
                fmos_pkg::REG_DOM_SIZE:     dom_reg    <= cfg_wdata[DW-1:0];
                fmos_pkg::REG_STRIDE:       stride_reg <= cfg_wdata[SW-1:0];
                fmos_pkg::REG_SELECT_VALUE: sel_reg    <= cfg_wdata[fmos_pkg::SEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (dom_reg == '0) begin
            dom_eff = DW'(1);
        end else if (dom_reg > DW'(DOM_LIM)) begin
            dom_eff = DW'(DOM_LIM);
        end else begin
            dom_eff = dom_reg;
        end
        priority if (stride_reg == '0) begin
            str_eff = SW'(1);
        end else if (stride_reg > SW'(STR_LIM)) begin
            str_eff = SW'(STR_LIM);
        end else begin
            str_eff = stride_reg;
        end
    end

    assign s_accept = s_valid && s_ready;
    assign k_inc    = CW'(k_reg) + CW'(1);
    assign k_wrap   = k_inc >= CW'(str_eff);
    assign j_inc    = DW'(j_reg) + DW'(1);
    assign j_end    = j_inc >= dom_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
            j_reg <= '0;
        end else if (s_accept) begin
            if (s_last_entry) begin
                k_reg <= '0;
                j_reg <= '0;
            end else if (k_wrap) begin
                k_reg <= '0;
                j_reg <= j_end ? '0 : j_inc[JW-1:0];
            end else begin
                k_reg <= k_inc[KW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_entry_reg <= s_entry_value;
            s1_last_reg  <= s_last_entry;
            s1_emit_reg  <= j_end;
            s1_first_reg <= (j_reg == '0);
            s1_pick_reg  <= !mode_reg || (j_reg == sel_reg);
            s1_k_reg     <= k_reg;
        end
    end

    assign s1_adv  = s1_valid_reg && (!s1_emit_reg || !m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;

    fmos_buffer #(
        .DEPTH (MAX_STRIDE),
        .AW    (KW)
    ) u_buffer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (k_reg),
        .wr_en   (s1_adv),
        .wr_addr (s1_k_reg),
        .wr_data (acc),
        .rd_data (prev)
    );

    always_comb begin
        cand = s1_pick_reg ? s1_entry_reg : fmos_pkg::NEG_MIN;
        if (s1_first_reg) begin
            acc = cand;
        end else begin
            acc = (cand > prev) ? cand : prev;
        end
        hs_cand = (acc > hs_reg) ? acc : hs_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hs_reg <= fmos_pkg::NEG_MIN;
        end else if (s1_adv) begin
            if (s1_last_reg) begin
                hs_reg <= fmos_pkg::NEG_MIN;
            end else if (s1_emit_reg) begin
                hs_reg <= hs_cand;
            end
        end
    end

    assign m_load       = s1_adv && s1_emit_reg;
    assign m_valid_next = m_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_value_reg   <= acc;
            m_last_reg    <= s1_last_reg;
            m_highest_reg <= hs_cand;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_value  = m_value_reg;
    assign m_result_last   = m_last_reg;
    assign m_highest_value = m_highest_reg;

endmodule

>>> src/fmos_buffer.sv
module fmos_buffer #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  fmos_pkg::value_t    wr_data,
    output fmos_pkg::value_t    rd_data
);

    fmos_pkg::value_t mem [DEPTH];
    fmos_pkg::value_t mem_q_reg;
    fmos_pkg::value_t byp_data_reg;
    logic             byp_hit_reg;

    // A read issued on the same edge as a write to the same entry sees the
    // old contents, so the written value is carried alongside.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_hit_reg <= 1'b0;
        end else if (rd_en) begin
            byp_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : mem_q_reg;

endmodule

>>> src/fmos_checker.sv
module fmos_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input fmos_pkg::value_t  m_result_value,
    input logic              m_result_last,
    input fmos_pkg::value_t  m_highest_value
);

    // A result that waits must not change.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value)
            && $stable(m_result_last) && $stable(m_highest_value))
        else $error("result changed while stalled");

    // The reported highest value includes the result that carries it.
    a_highest_covers: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_highest_value >= m_result_value)
        else $error("highest value below the result it travels with");

    // A fresh result's entry went through s1 into the result register.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result appeared without an accepted entry");

    // With the result register empty the pipeline cannot be stalled.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled although no result is waiting");

endmodule

bind factor_max_out_or_select fmos_checker u_fmos_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_result_value  (m_result_value),
    .m_result_last   (m_result_last),
    .m_highest_value (m_highest_value)
);
